// ===== sv/ncs_pkg.sv =====
// ncs_pkg: shared types, constants and helper functions of the nearest obstacle
// circling steer core. No dependencies.
`default_nettype none

package ncs_pkg;

    // datapath widths
    localparam int OP_W      = 17;          // signed multiplier operand
    localparam int ACC_W     = 2 * OP_W;    // product and accumulator
    localparam int DIV_NUM_W = 36;          // divider numerator magnitude
    localparam int DIV_DEN_W = 17;          // divider denominator
    localparam int DIV_CNT_W = 6;           // divider step counter
    localparam int QUO_W     = 28;          // quotient bits kept
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // angle constants, Q3.12 radians
    localparam logic signed [17:0] PI_PLUS_HALF_PI = 18'sd19302;
    localparam logic signed [17:0] TWO_PI          = 18'sd25736;
    localparam logic signed [17:0] FOUR_PI         = 18'sd51472;
    localparam logic signed [17:0] PI              = 18'sd12868;
    localparam logic signed [15:0] EIGHTH_PI       = 16'sd1608;
    localparam logic signed [15:0] ROTATE_RATE     = 16'sd819;
    // 1.3 m in Q8.8
    localparam logic [16:0]        RADIUS_OFFSET   = 17'd333;

    // configuration register reset values
    localparam logic [15:0]        RANGE_LIMIT_RST   = 16'd7680;
    localparam logic signed [15:0] ANGLE_START_RST   = -16'sd12868;
    localparam logic [11:0]        ANGLE_STEP_RST    = 12'd36;
    localparam logic signed [15:0] FORWARD_SPEED_RST = 16'sd4096;
    localparam logic signed [15:0] YAW_GAIN_RST      = 16'sd4096;
    localparam logic [15:0]        CIRCLE_RADIUS_RST = 16'd512;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_LIMIT   = 3'd0,
        REG_ANGLE_START   = 3'd1,
        REG_ANGLE_STEP    = 3'd2,
        REG_FORWARD_SPEED = 3'd3,
        REG_YAW_GAIN      = 3'd4,
        REG_CIRCLE_RADIUS = 3'd5
    } ncs_reg_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMMIT_MUL,
        ST_COMMIT_ADD,
        ST_TICK,
        ST_APPROACH,
        ST_ACCUM,
        ST_DIV_WAIT,
        ST_ROUND,
        ST_DONE
    } ncs_state_t;

    // saturate an accumulator value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > ACC_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -ACC_W'(32768)) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // drop 12 fraction bits rounding half up, then saturate
    function automatic logic signed [15:0] round_sat12(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-1:0] shr;
        sum = v + ACC_W'(2048);
        shr = sum >>> 12;
        return sat16(shr);
    endfunction

endpackage

`default_nettype wire

// ===== sv/ncs_scan.sv =====
// ncs_scan: running minimum of one laser scan and the index where it first occurs.
// Depends on nothing but its parameter.
`default_nettype none

module ncs_scan #(
    parameter int MAX_SAMPLES = 1024,
    parameter int IDX_W = $clog2(MAX_SAMPLES),
    parameter int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             sample_en,
    input  wire logic [15:0]      sample,
    input  wire logic             last,
    input  wire logic [15:0]      range_limit,
    output logic      [15:0]      min_next,
    output logic      [IDX_W-1:0] idx_next
);

    logic [15:0]      min_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      base_min;
    logic [IDX_W-1:0] base_idx;

    // start of a scan reloads the minimum from the range limit
    always_comb begin
        base_min = (count_reg == '0) ? range_limit : min_reg;
        base_idx = (count_reg == '0) ? '0 : idx_reg;
        min_next   = base_min;
        idx_next   = base_idx;
        count_next = count_reg;
        if (count_reg < CNT_W'(MAX_SAMPLES)) begin
            if (sample < base_min) begin
                min_next = sample;
                idx_next = count_reg[IDX_W-1:0];
            end
            count_next = count_reg + CNT_W'(1);
        end
        if (last) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (sample_en) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_en) begin
            min_reg <= min_next;
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ncs_mul.sv =====
// ncs_mul: shared signed multiplier with a registered product.
// Depends on ncs_pkg for operand widths.
`default_nettype none

module ncs_mul (
    input  wire logic                               aclk,
    input  wire logic signed [ncs_pkg::OP_W-1:0]    op_a,
    input  wire logic signed [ncs_pkg::OP_W-1:0]    op_b,
    output logic signed      [ncs_pkg::ACC_W-1:0]   product
);

    logic signed [ncs_pkg::ACC_W-1:0] product_reg;

    // one product per cycle, used by the commit and by approach and circling ticks
    always_ff @(posedge aclk) begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ===== sv/ncs_div.sv =====
// ncs_div: restoring divider, one quotient bit a cycle.
// Depends on ncs_pkg for widths.
`default_nettype none

module ncs_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [ncs_pkg::DIV_NUM_W-1:0]    numer,
    input  wire logic [ncs_pkg::DIV_DEN_W-1:0]    denom,
    output logic                                  done,
    output logic      [ncs_pkg::QUO_W-1:0]        quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [ncs_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ncs_pkg::DIV_DEN_W-1:0]     den_reg;
    logic [ncs_pkg::DIV_DEN_W-1:0]     rem_reg, rem_next;
    logic [ncs_pkg::DIV_NUM_W-1:0]     quo_reg, quo_next;
    logic [ncs_pkg::DIV_DEN_W:0]       trial;
    logic [ncs_pkg::DIV_DEN_W:0]       den_ext;

    // shift in one numerator bit and try a subtract
    always_comb begin
        trial     = {rem_reg, quo_reg[ncs_pkg::DIV_NUM_W-1]};
        den_ext   = {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = numer;
        end else if (busy_reg) begin
            if (trial >= den_ext) begin
                rem_next = ncs_pkg::DIV_DEN_W'(trial - den_ext);
                quo_next = {quo_reg[ncs_pkg::DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[ncs_pkg::DIV_DEN_W-1:0];
                quo_next = {quo_reg[ncs_pkg::DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + ncs_pkg::DIV_CNT_W'(1);
            if (cnt_reg == ncs_pkg::DIV_CNT_W'(ncs_pkg::DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            den_reg <= denom;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[ncs_pkg::QUO_W-1:0];

endmodule

`default_nettype wire

// ===== sv/nearest_obstacle_circling_steer_core.sv =====
// nearest_obstacle_circling_steer_core: top level, sequencer and datapath.
// Uses ncs_pkg, ncs_scan, ncs_mul and ncs_div.
// A last range sample adds the angle commit, ST_COMMIT_MUL then ST_COMMIT_ADD.
// A tick passes ST_APPROACH when approaching, goes straight to ST_DONE when
// rotating, and when circling waits on the 36-step speed feedforward divider.
// One item at a time; s_tready is high only while the sequencer idles.
// aresetn is synchronous, active low; it loads the register reset values and
// clears the scan and the committed obstacle.
`default_nettype none

module nearest_obstacle_circling_steer_core #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ncs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ncs_pkg::CFG_DAT_W-1:0]    cfg_data,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [15:0]                      s_tdata,   // [15:0] range_sample
    input  wire logic                             s_tuser,   // [0] cmd
    input  wire logic                             s_tlast,   // last_sample
    // result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [31:0]                      m_tdata    // [15:0] linear_speed,
                                                             // [31:16] yaw_rate
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int OP_W  = ncs_pkg::OP_W;
    localparam int ACC_W = ncs_pkg::ACC_W;

    // configuration registers
    logic [15:0]        range_limit_reg;
    logic signed [15:0] angle_start_reg;
    logic [11:0]        angle_step_reg;
    logic signed [15:0] forward_speed_reg;
    logic signed [15:0] yaw_gain_reg;
    logic [15:0]        circle_radius_reg;

    // committed obstacle and working registers
    logic [15:0]              dist_reg;
    logic signed [15:0]       angle_reg, angle_next;
    logic [IDX_W-1:0]         cidx_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [15:0]       lin_reg, lin_next;
    logic signed [15:0]       yaw_reg, yaw_next;
    logic signed [15:0]       m_lin_reg;
    logic signed [15:0]       m_yaw_reg;
    logic                     m_tvalid_reg;

    ncs_pkg::ncs_state_t state_reg, state_next;

    logic                     in_accept;
    logic                     sample_en;
    logic                     commit_en;
    logic                     load_out;
    logic [15:0]              scan_min;
    logic [IDX_W-1:0]         scan_idx;

    logic signed [OP_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W-1:0]  product;

    logic                     div_start;
    logic                     div_done;
    logic [ncs_pkg::QUO_W-1:0] quotient;
    logic [ncs_pkg::DIV_NUM_W-1:0] div_numer;
    logic [ncs_pkg::DIV_DEN_W-1:0] div_denom;
    logic [16:0]              speed_ext, speed_mag;

    logic                     approach;
    logic signed [17:0]       wrap_x, wrap_y;
    logic signed [15:0]       err;
    logic                     wide_err;
    logic signed [16:0]       gap;
    logic signed [ACC_W-1:0]  gap_term;
    logic signed [ACC_W-1:0]  q_signed;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign sample_en = in_accept && !s_tuser;
    assign commit_en = sample_en && s_tlast;
    assign load_out  = (state_reg == ncs_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    // scan tracking
    ncs_scan #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_en   (sample_en),
        .sample      (s_tdata),
        .last        (s_tlast),
        .range_limit (range_limit_reg),
        .min_next    (scan_min),
        .idx_next    (scan_idx)
    );

    // shared multiplier
    ncs_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    // speed feedforward divider
    ncs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .done     (div_done),
        .quotient (quotient)
    );

    // tick decision terms: approach test and wrapped angle error
    always_comb begin
        approach = dist_reg > circle_radius_reg;
        wrap_x   = ncs_pkg::PI_PLUS_HALF_PI - {{2{angle_reg[15]}}, angle_reg};
        if (wrap_x < 18'sd0) begin
            wrap_y = wrap_x + ncs_pkg::TWO_PI;
        end else if (wrap_x >= ncs_pkg::FOUR_PI) begin
            wrap_y = wrap_x - ncs_pkg::FOUR_PI;
        end else if (wrap_x >= ncs_pkg::TWO_PI) begin
            wrap_y = wrap_x - ncs_pkg::TWO_PI;
        end else begin
            wrap_y = wrap_x;
        end
        err      = 16'(wrap_y - ncs_pkg::PI);
        wide_err = (err > ncs_pkg::EIGHTH_PI) || (err < -ncs_pkg::EIGHTH_PI);
    end

    // divider operands: |speed| * 2^20 + d/2 over d = radius + 1.3 m
    always_comb begin
        speed_ext = {forward_speed_reg[15], forward_speed_reg};
        speed_mag = speed_ext[16] ? 17'(-speed_ext) : speed_ext;
        div_denom = {1'b0, circle_radius_reg} + ncs_pkg::RADIUS_OFFSET;
        div_numer = {speed_mag[15:0], 20'd0} + ncs_pkg::DIV_NUM_W'(div_denom[16:1]);
        q_signed  = forward_speed_reg[15] ? -ACC_W'(quotient) : ACC_W'(quotient);
        gap       = $signed({1'b0, circle_radius_reg}) - $signed({1'b0, dist_reg});
        gap_term  = {{2{gap[16]}}, gap, 15'd0};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ncs_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser) begin
                        state_next = ncs_pkg::ST_TICK;
                    end else if (s_tlast) begin
                        state_next = ncs_pkg::ST_COMMIT_MUL;
                    end
                end
            end
            ncs_pkg::ST_COMMIT_MUL: state_next = ncs_pkg::ST_COMMIT_ADD;
            ncs_pkg::ST_COMMIT_ADD: state_next = ncs_pkg::ST_IDLE;
            ncs_pkg::ST_TICK: begin
                if (approach) begin
                    state_next = ncs_pkg::ST_APPROACH;
                end else if (wide_err) begin
                    state_next = ncs_pkg::ST_DONE;
                end else begin
                    state_next = ncs_pkg::ST_ACCUM;
                end
            end
            ncs_pkg::ST_APPROACH:   state_next = ncs_pkg::ST_DONE;
            ncs_pkg::ST_ACCUM:      state_next = ncs_pkg::ST_DIV_WAIT;
            ncs_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ncs_pkg::ST_ROUND;
                end
            end
            ncs_pkg::ST_ROUND:      state_next = ncs_pkg::ST_DONE;
            ncs_pkg::ST_DONE: begin
                if (load_out) begin
                    state_next = ncs_pkg::ST_IDLE;
                end
            end
            default:                state_next = ncs_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: input ready, multiplier operands and divider start
    always_comb begin
        s_tready  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (state_reg)
            ncs_pkg::ST_IDLE: s_tready = 1'b1;
            ncs_pkg::ST_COMMIT_MUL: begin
                mul_a = OP_W'(cidx_reg);
                mul_b = OP_W'(angle_step_reg);
            end
            ncs_pkg::ST_TICK: begin
                mul_a = {yaw_gain_reg[15], yaw_gain_reg};
                mul_b = approach ? {angle_reg[15], angle_reg} : {err[15], err};
                div_start = !approach && !wide_err;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        angle_next = angle_reg;
        acc_next   = acc_reg;
        lin_next   = lin_reg;
        yaw_next   = yaw_reg;
        case (state_reg)
            ncs_pkg::ST_COMMIT_ADD: begin
                angle_next = ncs_pkg::sat16({{(ACC_W-16){angle_start_reg[15]}},
                                             angle_start_reg} + product);
            end
            ncs_pkg::ST_TICK: begin
                // rotate in place when the error is wide
                lin_next = 16'sd0;
                yaw_next = ncs_pkg::ROTATE_RATE;
            end
            ncs_pkg::ST_APPROACH: begin
                lin_next = forward_speed_reg;
                yaw_next = ncs_pkg::round_sat12(-product);
            end
            ncs_pkg::ST_ACCUM: begin
                acc_next = product + gap_term;
            end
            ncs_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    acc_next = acc_reg - q_signed;
                end
            end
            ncs_pkg::ST_ROUND: begin
                lin_next = forward_speed_reg;
                yaw_next = ncs_pkg::round_sat12(acc_reg);
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    // control, configuration and committed obstacle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ncs_pkg::ST_IDLE;
            m_tvalid_reg      <= 1'b0;
            range_limit_reg   <= ncs_pkg::RANGE_LIMIT_RST;
            angle_start_reg   <= ncs_pkg::ANGLE_START_RST;
            angle_step_reg    <= ncs_pkg::ANGLE_STEP_RST;
            forward_speed_reg <= ncs_pkg::FORWARD_SPEED_RST;
            yaw_gain_reg      <= ncs_pkg::YAW_GAIN_RST;
            circle_radius_reg <= ncs_pkg::CIRCLE_RADIUS_RST;
            dist_reg          <= '0;
            angle_reg         <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    ncs_pkg::REG_RANGE_LIMIT:   range_limit_reg   <= cfg_data;
                    ncs_pkg::REG_ANGLE_START:   angle_start_reg   <= cfg_data;
                    ncs_pkg::REG_ANGLE_STEP:    angle_step_reg    <= cfg_data[11:0];
                    ncs_pkg::REG_FORWARD_SPEED: forward_speed_reg <= cfg_data;
                    ncs_pkg::REG_YAW_GAIN:      yaw_gain_reg      <= cfg_data;
                    ncs_pkg::REG_CIRCLE_RADIUS: circle_radius_reg <= cfg_data;
                    default: begin
                        range_limit_reg <= range_limit_reg;
                    end
                endcase
            end
            if (commit_en) begin
                dist_reg <= scan_min;
            end
            angle_reg <= angle_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (commit_en) begin
            cidx_reg <= scan_idx;
        end
        acc_reg <= acc_next;
        lin_reg <= lin_next;
        yaw_reg <= yaw_next;
        if (load_out) begin
            m_lin_reg <= lin_reg;
            m_yaw_reg <= yaw_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_yaw_reg, m_lin_reg};

endmodule

`default_nettype wire

// ===== test/nearest_obstacle_circling_steer_core_tb.sv =====
// nearest_obstacle_circling_steer_core_tb: self-checking testbench for the steer core.
// Drives scans and ticks, predicts every drive command in place and compares.
// Depends on ncs_pkg and nearest_obstacle_circling_steer_core.

module nearest_obstacle_circling_steer_core_tb;

    // item kinds on s_tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // register indexes past the last real register
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    // angle and steering constants, Q3.12; RADIUS_PAD is Q8.8
    localparam longint QUARTER_TURN = 6434;
    localparam longint HALF_TURN    = 12868;
    localparam longint FULL_TURN    = 25736;
    localparam longint HEADING_WIN  = 1608;
    localparam longint SPIN_RATE    = 819;
    localparam longint RADIUS_PAD   = 333;

    localparam int SCAN_CAP       = 1024;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    // configuration flavors for the random phases
    localparam int PHASE_RANDOM = 0;
    localparam int PHASE_CIRCLE = 1;
    localparam int PHASE_HIGH   = 2;
    localparam int PHASE_LOW    = 3;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] lin;
    } drive_cmd_t;

    typedef struct packed {
        logic               cmd;
        logic [15:0]        sample;
        logic               last_s;
        logic               typed;
        logic signed [15:0] lin;
        logic signed [15:0] yaw;
    } plan_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    // predictor copy of the registers
    logic [15:0]        p_range_limit;
    logic signed [15:0] p_angle_start;
    logic [11:0]        p_angle_step;
    logic signed [15:0] p_fwd_speed;
    logic signed [15:0] p_yaw_gain;
    logic [15:0]        p_radius;

    // predictor copy of the scan and the committed obstacle
    logic [15:0]        scan_min;
    logic [9:0]         scan_idx;
    logic [10:0]        scan_len;
    logic signed [15:0] obst_angle;
    logic [15:0]        near_dist;

    drive_cmd_t pending_cmds[$];
    logic [15:0] prev_range = '0;

    int in_idle_pct  = 18;
    int out_idle_pct = 18;
    int hold_cycles  = 0;
    int stall_count  = 0;

    int err_count    = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int scans_done   = 0;
    int reg_writes   = 0;
    int n_approach   = 0;
    int n_rotate     = 0;
    int n_circle     = 0;

    // directed items at reset configuration
    plan_row_t plan [0:12] = '{
        '{CMD_TICK,   16'h0000, 1'b0, 1'b1, 16'sd0, 16'(SPIN_RATE)},  // tick before any scan
        '{CMD_TICK,   16'hFFFF, 1'b1, 1'b1, 16'sd0, 16'(SPIN_RATE)},  // ignored fields set
        '{CMD_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{CMD_SAMPLE, 16'h0300, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{CMD_SAMPLE, 16'h0300, 1'b0, 1'b0, 16'sd0, 16'sd0},          // tie keeps first
        '{CMD_SAMPLE, 16'h0500, 1'b1, 1'b0, 16'sd0, 16'sd0},
        '{CMD_TICK,   16'h0000, 1'b0, 1'b0, 16'sd0, 16'sd0},          // approach
        '{CMD_SAMPLE, 16'h0000, 1'b1, 1'b0, 16'sd0, 16'sd0},          // one-sample scan
        '{CMD_TICK,   16'h0000, 1'b0, 1'b1, 16'sd0, 16'(SPIN_RATE)},  // rotate in place
        '{CMD_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 16'sd0, 16'sd0},          // nothing under limit
        '{CMD_TICK,   16'h0000, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{CMD_SAMPLE, 16'h1E00, 1'b1, 1'b0, 16'sd0, 16'sd0},          // equal to limit
        '{CMD_TICK,   16'hA5A5, 1'b0, 1'b0, 16'sd0, 16'sd0}
    };

    nearest_obstacle_circling_steer_core #(
        .MAX_SAMPLES(SCAN_CAP)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return 16'(v);
    endfunction

    // drop 12 fraction bits, half up
    function automatic longint round_q12(input longint v);
        return (v + 2048) >>> 12;
    endfunction

    // nearest, ties away from zero, d positive
    function automatic longint ratio_round(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    // advance the scan, or work out the drive command for a tick
    function automatic bit steer_step(input logic cmd, input logic [15:0] sample,
                                      input logic last_s, output drive_cmd_t res);
        longint lin;
        longint yaw;
        longint err;
        longint acc;
        res = '0;
        if (cmd == CMD_SAMPLE) begin
            if (scan_len == 0) begin
                scan_min = p_range_limit;
                scan_idx = '0;
            end
            if (scan_len < SCAN_CAP) begin
                if (sample < scan_min) begin
                    scan_min = sample;
                    scan_idx = scan_len[9:0];
                end
                scan_len++;
            end
            if (last_s) begin
                obst_angle = clamp16(longint'(p_angle_start)
                                     + longint'(scan_idx) * longint'(p_angle_step));
                near_dist = scan_min;
                scan_min = p_range_limit;
                scan_idx = '0;
                scan_len = '0;
                scans_done++;
            end
            return 1'b0;
        end
        lin = p_fwd_speed;
        if (near_dist > p_radius) begin
            yaw = round_q12(-(longint'(obst_angle) * longint'(p_yaw_gain)));
            n_approach++;
        end else begin
            // heading error to a quarter turn, wrapped into one turn
            err = (QUARTER_TURN - longint'(obst_angle) + HALF_TURN) % FULL_TURN;
            if (err < 0) err += FULL_TURN;
            err -= HALF_TURN;
            if (err > HEADING_WIN || err < -HEADING_WIN) begin
                lin = 0;
                yaw = SPIN_RATE;
                n_rotate++;
            end else begin
                acc = longint'(p_yaw_gain) * err;
                acc += (longint'(p_radius) - longint'(near_dist)) * 32768;
                acc -= ratio_round(longint'(p_fwd_speed) * 1048576,
                                   longint'(p_radius) + RADIUS_PAD);
                yaw = round_q12(acc);
                n_circle++;
            end
        end
        res.lin = clamp16(lin);
        res.yaw = clamp16(yaw);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        // keep the log short when things go badly wrong
        if (err_count < 100) begin
            $display("mismatch %s: got %0d, want %0d (result %0d)", what, got, want,
                     results_seen);
        end
        err_count++;
    endtask

    task automatic check_cmd(input logic [31:0] word);
        drive_cmd_t got;
        drive_cmd_t want;
        got = word;
        results_seen++;
        if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected drive command, yaw_rate", got.yaw, 0);
        end else begin
            want = pending_cmds.pop_front();
            if (got.lin !== want.lin) report_mismatch("linear_speed", got.lin, want.lin);
            if (got.yaw !== want.yaw) report_mismatch("yaw_rate", got.yaw, want.yaw);
        end
    endtask

    task automatic send_item(input logic cmd, input logic [15:0] sample, input logic last_s,
                             input logic typed = 1'b0, input drive_cmd_t typed_cmd = '0);
        drive_cmd_t pred;
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= cmd;
        s_tlast  <= last_s;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        items_sent++;
        if (steer_step(cmd, sample, last_s, pred)) begin
            pending_cmds.push_back(typed ? typed_cmd : pred);
        end
        // random gap before the next item
        if ($urandom_range(99) < in_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 50);
        end
    endtask

    // stop offering, wait for every pending command, let the sequencer settle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        reg_writes++;
        case (idx)
            ncs_pkg::REG_RANGE_LIMIT:   p_range_limit = val;
            ncs_pkg::REG_ANGLE_START:   p_angle_start = val;
            ncs_pkg::REG_ANGLE_STEP:    p_angle_step  = val[11:0];
            ncs_pkg::REG_FORWARD_SPEED: p_fwd_speed   = val;
            ncs_pkg::REG_YAW_GAIN:      p_yaw_gain    = val;
            ncs_pkg::REG_CIRCLE_RADIUS: p_radius      = val;
            default: ;
        endcase
    endtask

    task automatic configure(input int kind);
        logic [15:0] v [0:5];
        case (kind)
            PHASE_LOW: begin
                v = '{16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h8000, 16'h0000};
            end
            PHASE_HIGH: begin
                v = '{16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
            end
            PHASE_CIRCLE: begin
                // heading near a quarter turn, obstacle mostly inside the radius
                v[0] = 16'($urandom);
                v[1] = 16'($urandom_range(4000, 7000));
                v[2] = 16'($urandom_range(0, 40));
                v[3] = 16'($urandom);
                v[4] = 16'($urandom);
                v[5] = 16'($urandom_range(256, 65535));
            end
            default: begin
                foreach (v[k]) v[k] = 16'($urandom);
            end
        endcase
        write_reg(ncs_pkg::REG_RANGE_LIMIT,   v[0]);
        write_reg(ncs_pkg::REG_ANGLE_START,   v[1]);
        write_reg(ncs_pkg::REG_ANGLE_STEP,    v[2]);
        write_reg(ncs_pkg::REG_FORWARD_SPEED, v[3]);
        write_reg(ncs_pkg::REG_YAW_GAIN,      v[4]);
        write_reg(ncs_pkg::REG_CIRCLE_RADIUS, v[5]);
        write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
    endtask

    // range value: random, inside the radius, a repeat, or an edge value
    function automatic logic [15:0] pick_range();
        int r;
        logic [15:0] v;
        r = $urandom_range(99);
        if (r < 40) begin
            v = 16'($urandom);
        end else if (r < 70) begin
            v = 16'($urandom_range(0, p_radius));
        end else if (r < 85) begin
            v = prev_range;
        end else begin
            case ($urandom_range(3))
                0: v = 16'h0000;
                1: v = 16'hFFFF;
                2: v = p_range_limit;
                default: v = p_range_limit - 16'd1;
            endcase
        end
        prev_range = v;
        return v;
    endfunction

    // mostly whole scans followed by ticks, some stray ticks and broken scans
    task automatic run_traffic(input int budget);
        int first;
        int len;
        int r;
        int i;
        first = items_sent;
        while (items_sent - first < budget) begin
            r = $urandom_range(99);
            if (r < 80) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(41, 200)
                                               : $urandom_range(1, 40);
                for (i = 0; i < len; i++) send_item(CMD_SAMPLE, pick_range(), i == len - 1);
                repeat ($urandom_range(1, 3)) send_item(CMD_TICK, 16'($urandom), 1'($urandom));
            end else if (r < 90) begin
                send_item(CMD_TICK, 16'($urandom), 1'($urandom));
            end else begin
                send_item(CMD_SAMPLE, pick_range(), 1'($urandom));
            end
        end
    endtask

    // result side: check, then pick ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) check_cmd(m_tdata);
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int ph;
        int kinds [0:9];
        drive_cmd_t fixed;

        kinds = '{PHASE_HIGH, PHASE_RANDOM, PHASE_CIRCLE, PHASE_CIRCLE, PHASE_LOW,
                  PHASE_RANDOM, PHASE_CIRCLE, PHASE_RANDOM, PHASE_CIRCLE, PHASE_RANDOM};

        p_range_limit = ncs_pkg::RANGE_LIMIT_RST;
        p_angle_start = ncs_pkg::ANGLE_START_RST;
        p_angle_step  = ncs_pkg::ANGLE_STEP_RST;
        p_fwd_speed   = ncs_pkg::FORWARD_SPEED_RST;
        p_yaw_gain    = ncs_pkg::YAW_GAIN_RST;
        p_radius      = ncs_pkg::CIRCLE_RADIUS_RST;
        scan_min      = ncs_pkg::RANGE_LIMIT_RST;
        scan_idx      = '0;
        scan_len      = '0;
        obst_angle    = '0;
        near_dist     = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed items
        foreach (plan[k]) begin
            fixed.lin = plan[k].lin;
            fixed.yaw = plan[k].yaw;
            send_item(plan[k].cmd, plan[k].sample, plan[k].last_s, plan[k].typed, fixed);
        end
        quiesce();

        // random phases under changing settings
        for (ph = 0; ph < 10; ph++) begin
            configure(kinds[ph]);
            in_idle_pct  = (ph == 1) ? 0 : 18;
            out_idle_pct = (ph == 1) ? 0 : 18;
            if (ph == 3) begin
                // receiver holds off while ticks keep coming
                hold_cycles = HOLD_CYCLES;
                repeat (12) send_item(CMD_TICK, 16'($urandom), 1'($urandom));
            end
            run_traffic(45);
            quiesce();
        end

        // scan left open across a range limit change, then one under the new limit
        send_item(CMD_SAMPLE, 16'd500, 1'b0);
        send_item(CMD_SAMPLE, 16'd400, 1'b0);
        send_item(CMD_SAMPLE, 16'd450, 1'b0);
        quiesce();
        write_reg(ncs_pkg::REG_RANGE_LIMIT, 16'd50);
        send_item(CMD_SAMPLE, 16'd600, 1'b1);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_SAMPLE, 16'd60, 1'b0);
        send_item(CMD_SAMPLE, 16'd70, 1'b1);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        quiesce();

        if (pending_cmds.size() != 0) begin
            report_mismatch("drive commands never produced", pending_cmds.size(), 0);
        end

        $display("run covered %0d items, %0d scans committed, %0d register writes",
                 items_sent, scans_done, reg_writes);
        $display("drive commands checked %0d: approach %0d, rotate %0d, circle %0d",
                 results_seen, n_approach, n_rotate, n_circle);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
